// ===== src/dflm_pkg.sv =====
// ----------------------------------------------------------------------------
// dflm_pkg: shared types and constants of the descriptor free-list manager
// Request and result layouts, descriptor entry layout, operation and status
// codes, and the link value an untouched entry holds after a rebuild.
// ----------------------------------------------------------------------------
package dflm_pkg;

	localparam int MAX_ENTRIES = 256;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int QS_W        = IDX_W + 1;
	localparam int LINK_W      = 16;

	localparam logic [LINK_W-1:0] END_MARK = 16'hFFFF;

	localparam logic [1:0] KIND_ALLOC = 2'd0;
	localparam logic [1:0] KIND_FREE  = 2'd1;
	localparam logic [1:0] KIND_SET   = 2'd2;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_EMPTY   = 2'd1;
	localparam logic [1:0] STAT_IGNORED = 2'd2;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] slot;
		logic [63:0] buf_addr;
		logic [31:0] buf_len;
		logic [15:0] desc_flags_in;
		logic [15:0] link_in;
	} dflm_req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] granted;
		logic [8:0] released;
		logic [8:0] free_left;
	} dflm_result_t;

	typedef struct packed {
		logic [63:0]       addr;
		logic [31:0]       len;
		logic [15:0]       flags;
		logic [LINK_W-1:0] link;
	} dflm_entry_t;

	// Link held by an entry that has not been written since the last rebuild:
	// the entries form one list in index order, the last one ends it.
	function automatic logic [LINK_W-1:0] reset_link(input logic [IDX_W-1:0] idx,
			input logic [QS_W-1:0] qs);
		logic [QS_W-1:0] nxt;
		nxt = {1'b0, idx} + QS_W'(1);
		return (nxt < qs) ? LINK_W'(nxt) : END_MARK;
	endfunction

endpackage

// ===== src/descriptor_free_list_manager.sv =====
// ----------------------------------------------------------------------------
// descriptor_free_list_manager: descriptor table with a linked free list
// Allocates, frees chains of and writes descriptors of a split-ring table
// whose free entries are linked through their link fields.
// ----------------------------------------------------------------------------
//
//  Channel   | Ports                       | Handshake
//  ----------+-----------------------------+------------------------------------
//  request   | start, busy, req            | taken at an edge with start & !busy
//  result    | done, result                | done high for one cycle, no stall
//  config    | cfg_wr_en, cfg_wr_data      | written with cfg_wr_en & !busy
//
// The table lives in one synchronous memory of 256 entries with a registered
// read. A set request, and any request that is rejected, is answered from
// the idle state: the result appears in the cycle after the request is taken.
// An allocate reads the head entry, then clears it and pops it. A free walks
// the chain entry by entry, reading the next entry in the same cycle as it
// writes back the current one. Reset needs no clearing pass: a valid bit per
// entry marks entries written since the last rebuild, and an entry without it
// reads as its rebuilt value. The result receiver cannot stall, so busy
// depends only on work in flight.
//
module descriptor_free_list_manager (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  dflm_pkg::dflm_req_t     req,
	output logic                    done,
	output dflm_pkg::dflm_result_t  result,
	input  logic                    cfg_wr_en,
	input  logic [8:0]              cfg_wr_data
);
	import dflm_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ALLOC,
		ST_WALK
	} state_t;

	state_t            state_q;
	logic [QS_W-1:0]   qs_q;
	logic [LINK_W-1:0] head_q;
	logic [QS_W-1:0]   free_q;
	logic [QS_W-1:0]   rel_q;
	logic [MAX_ENTRIES-1:0] valid_q;
	logic              done_q;
	dflm_result_t      result_q;

	// Descriptor memory and its registered read side.
	dflm_entry_t       desc_mem [MAX_ENTRIES];
	dflm_entry_t       rd_data_s1;
	logic [IDX_W-1:0]  rd_idx_s1;
	logic              rd_vld_s1;
	logic              rd_fwd_s1;
	dflm_entry_t       fwd_data_s1;

	logic              rd_en;
	logic [IDX_W-1:0]  rd_addr;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	dflm_entry_t       wr_data;
	dflm_entry_t       entry_rd;

	logic              accept;
	logic              slot_ok;
	logic              alloc_ok;
	logic              cfg_ok;
	logic [QS_W-1:0]   rel_inc;
	logic [QS_W-1:0]   free_inc;
	logic              walk_more;

	// Outcome of a request taken in the idle state.
	logic [1:0]        acc_status;
	logic              acc_done;
	state_t            acc_state;

	assign accept  = start && (state_q == ST_IDLE);
	assign slot_ok = (req.slot < 16'(qs_q));
	assign alloc_ok = (free_q != '0) && (head_q < LINK_W'(qs_q));

	// Only a power of two from one up to the table depth is taken as a size.
	assign cfg_ok = (cfg_wr_data != '0)
		&& ((cfg_wr_data & (cfg_wr_data - 9'd1)) == '0)
		&& (cfg_wr_data <= 9'(MAX_ENTRIES));

	// The entry read last cycle: a write to the same entry in the read cycle
	// wins, then the memory if the entry was written since the rebuild.
	always_comb begin
		if (rd_fwd_s1) begin
			entry_rd = fwd_data_s1;
		end else if (rd_vld_s1) begin
			entry_rd = rd_data_s1;
		end else begin
			entry_rd      = '0;
			entry_rd.link = reset_link(rd_idx_s1, qs_q);
		end
	end

	assign rel_inc  = rel_q + QS_W'(1);
	assign free_inc = (free_q < qs_q) ? free_q + QS_W'(1) : free_q;

	// The walk goes on while the chain continues, stays in range and has not
	// yet visited as many entries as the queue holds.
	assign walk_more = entry_rd.flags[0] && (entry_rd.link < LINK_W'(qs_q))
		&& (rel_inc != qs_q);

	// Allocate and free go on to their own states when they can proceed;
	// everything else answers straight away.
	always_comb begin
		acc_status = STAT_OK;
		acc_done   = 1'b1;
		acc_state  = ST_IDLE;
		case (req.kind)
			KIND_ALLOC: begin
				if (alloc_ok) begin
					acc_done  = 1'b0;
					acc_state = ST_ALLOC;
				end else begin
					acc_status = STAT_EMPTY;
				end
			end
			KIND_FREE: begin
				if (slot_ok) begin
					acc_done  = 1'b0;
					acc_state = ST_WALK;
				end else begin
					acc_status = STAT_IGNORED;
				end
			end
			KIND_SET: begin
				if (!slot_ok) begin
					acc_status = STAT_IGNORED;
				end
			end
			default: begin
				acc_status = STAT_IGNORED;
			end
		endcase
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (req.kind)
						KIND_ALLOC: begin
							rd_en   = alloc_ok;
							rd_addr = head_q[IDX_W-1:0];
						end
						KIND_FREE: begin
							rd_en   = slot_ok;
							rd_addr = req.slot[IDX_W-1:0];
						end
						KIND_SET: begin
							wr_en   = slot_ok;
							wr_addr = req.slot[IDX_W-1:0];
							wr_data = '{addr: req.buf_addr, len: req.buf_len,
								flags: req.desc_flags_in, link: req.link_in};
						end
						default: begin
						end
					endcase
				end
			end
			ST_ALLOC: begin
				wr_en   = 1'b1;
				wr_addr = rd_idx_s1;
			end
			ST_WALK: begin
				wr_en        = 1'b1;
				wr_addr      = rd_idx_s1;
				wr_data.link = head_q;
				rd_en        = walk_more;
				rd_addr      = entry_rd.link[IDX_W-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			desc_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1  <= desc_mem[rd_addr];
			rd_idx_s1   <= rd_addr;
			rd_vld_s1   <= valid_q[rd_addr];
			rd_fwd_s1   <= wr_en && (wr_addr == rd_addr);
			fwd_data_s1 <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			qs_q     <= QS_W'(MAX_ENTRIES);
			head_q   <= '0;
			free_q   <= QS_W'(MAX_ENTRIES);
			rel_q    <= '0;
			valid_q  <= '0;
			done_q   <= 1'b0;
			result_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cfg_wr_en && cfg_ok) begin
						// Rebuild: every entry returns to its reset contents.
						qs_q    <= cfg_wr_data;
						head_q  <= '0;
						free_q  <= cfg_wr_data;
						valid_q <= '0;
						done_q  <= 1'b0;
					end else if (accept) begin
						result_q <= '{status: acc_status, granted: '0, released: '0,
							free_left: free_q};
						rel_q    <= '0;
						done_q   <= acc_done;
						state_q  <= acc_state;
						if (wr_en) begin
							valid_q[wr_addr] <= 1'b1;
						end
					end else begin
						done_q <= 1'b0;
					end
				end
				ST_ALLOC: begin
					head_q           <= entry_rd.link;
					free_q           <= free_q - QS_W'(1);
					valid_q[wr_addr] <= 1'b1;
					result_q         <= '{status: STAT_OK, granted: 8'(rd_idx_s1),
						released: '0, free_left: free_q - QS_W'(1)};
					done_q           <= 1'b1;
					state_q          <= ST_IDLE;
				end
				ST_WALK: begin
					head_q           <= LINK_W'(rd_idx_s1);
					free_q           <= free_inc;
					rel_q            <= rel_inc;
					valid_q[wr_addr] <= 1'b1;
					done_q           <= !walk_more;
					if (!walk_more) begin
						result_q <= '{status: STAT_OK, granted: '0,
							released: 9'(rel_inc), free_left: 9'(free_inc)};
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					done_q  <= 1'b0;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the descriptor free-list manager
// Drives allocate, free-chain and set requests through the start/busy port,
// keeps its own copy of the descriptor table and free list to predict every
// result, and checks each done strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
	import dflm_pkg::*;

	// Kind 3 has no meaning in the block and must come back as ignored.
	localparam logic [1:0] KIND_UNKNOWN = 2'd3;

	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 91;

	// Free-list model: a table of descriptors, the head of the free list and
	// the number of free entries, all under the current queue size.
	class free_list_scoreboard;
		dflm_entry_t  entries[MAX_ENTRIES];
		logic [15:0]  head;
		logic [8:0]   free_count;
		logic [8:0]   entries_in_use;
		dflm_result_t expected_q[$];
		int           errors;

		function new();
			errors = 0;
			rebuild(9'd256);
		endfunction

		// Every entry is cleared and the free list runs through the table in
		// index order; the last entry in use ends it.
		function void rebuild(logic [8:0] qs);
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				entries[i] = '0;
				entries[i].link = (i + 1 < qs) ? 16'(i + 1) : END_MARK;
			end
			entries_in_use = qs;
			head = '0;
			free_count = qs;
		endfunction

		// Only a power of two from 1 to the table size is taken; anything
		// else leaves the table as it is.
		function void apply_queue_size(logic [8:0] v);
			if (v != 0 && (v & (v - 9'd1)) == 0 && v <= MAX_ENTRIES)
				rebuild(v);
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// Applies one accepted request to the model and queues the result it
		// should produce.
		function dflm_result_t note_request(dflm_req_t r);
			dflm_result_t res;
			logic [15:0]  cur;
			logic [15:0]  nxt;
			logic         more;
			int           released;
			res = '0;
			released = 0;
			case (r.kind)
				KIND_ALLOC: begin
					// An empty count or a head outside the table (the end mark
					// included) both make the allocate fail.
					if (free_count == 0 || head >= entries_in_use) begin
						res.status = STAT_EMPTY;
					end else begin
						cur = head;
						head = entries[cur[7:0]].link;
						free_count--;
						entries[cur[7:0]] = '0;
						res.granted = cur[7:0];
					end
				end
				KIND_FREE: begin
					if (r.slot >= entries_in_use) begin
						res.status = STAT_IGNORED;
					end else begin
						cur = r.slot;
						// The walk is bounded by the queue size, so a cyclic
						// chain stops after one lap.
						while (released < entries_in_use) begin
							nxt = entries[cur[7:0]].link;
							more = entries[cur[7:0]].flags[0];
							entries[cur[7:0]] = '0;
							entries[cur[7:0]].link = head;
							head = cur;
							if (free_count < entries_in_use)
								free_count++;
							released++;
							if (!more || nxt >= entries_in_use)
								break;
							cur = nxt;
						end
					end
				end
				KIND_SET: begin
					if (r.slot >= entries_in_use) begin
						res.status = STAT_IGNORED;
					end else begin
						entries[r.slot[7:0]].addr  = r.buf_addr;
						entries[r.slot[7:0]].len   = r.buf_len;
						entries[r.slot[7:0]].flags = r.desc_flags_in;
						entries[r.slot[7:0]].link  = r.link_in;
					end
				end
				default: res.status = STAT_IGNORED;
			endcase
			res.released = 9'(released);
			res.free_left = free_count;
			expected_q.push_back(res);
			return res;
		endfunction

		task report(string msg);
			$display("[%0t] dflm check: %s", $time, msg);
			errors++;
		endtask

		task check_result(dflm_result_t got);
			dflm_result_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("result with no request outstanding (status %0d)",
					got.status));
				return;
			end
			want = expected_q.pop_front();
			if (got.status !== want.status)
				report($sformatf("status %0d, predicted %0d", got.status, want.status));
			if (got.granted !== want.granted)
				report($sformatf("granted %0d, predicted %0d", got.granted, want.granted));
			if (got.released !== want.released)
				report($sformatf("released %0d, predicted %0d", got.released,
					want.released));
			if (got.free_left !== want.free_left)
				report($sformatf("free_left %0d, predicted %0d", got.free_left,
					want.free_left));
		endtask
	endclass

	logic         clk = 1'b0;
	logic         arst_n;
	logic         start;
	logic         busy;
	dflm_req_t    req;
	logic         done;
	dflm_result_t result;
	logic         cfg_wr_en;
	logic [8:0]   cfg_wr_data;

	free_list_scoreboard sb;
	int                  sent;
	int                  idle_pct;

	// Queue sizes visited by the random phases, each written after a value
	// that the block has to refuse.
	int phase_qs[PHASES]  = '{4, 2, 16, 256, 1, 8, 64, 32};
	int refused_qs[PHASES] = '{0, 3, 257, 511, 96, 6, 384, 255};
	// Sender idling per phase: none, heavy, light, none. The result side
	// has no stall, so there is nothing to apply on that side.
	int idle_plan[4] = '{0, 84, 8, 0};

	descriptor_free_list_manager dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req         (req),
		.done        (done),
		.result      (result),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	always #5 clk = ~clk;

	// The DUT updates its outputs with nonblocking assignments, so sampling
	// here sees the values that held during the cycle that this edge ends.
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(result);
	end

	function automatic dflm_req_t make_request(logic [1:0] kind, logic [15:0] slot,
			logic [63:0] addr, logic [31:0] len, logic [15:0] flags, logic [15:0] link);
		dflm_req_t r;
		r.kind          = kind;
		r.slot          = slot;
		r.buf_addr      = addr;
		r.buf_len       = len;
		r.desc_flags_in = flags;
		r.link_in       = link;
		return r;
	endfunction

	// Noise request: any kind, slots mostly inside the table but now and then
	// anywhere in the 16-bit range, links half the time inside the table.
	function automatic dflm_req_t random_request(int qs);
		dflm_req_t r;
		r.kind = 2'($urandom_range(0, 3));
		r.slot = ($urandom_range(0, 3) != 0) ? 16'($urandom_range(0, qs - 1))
			: 16'($urandom);
		r.buf_addr = {$urandom, $urandom};
		r.buf_len = $urandom;
		r.desc_flags_in = 16'($urandom);
		r.link_in = $urandom_range(0, 1) ? 16'($urandom_range(0, qs - 1))
			: 16'($urandom);
		return r;
	endfunction

	// Holds start low until every predicted result has come back and the
	// block has gone idle.
	task automatic drain();
		start <= 1'b0;
		while (sb.pending() != 0 || busy)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// Presents one request and waits for the edge that takes it. Start is
	// left high so that back-to-back requests need no extra cycle.
	task automatic send(input dflm_req_t r, output dflm_result_t predicted);
		if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		if ($urandom_range(0, 199) == 0)
			drain();
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predicted = sb.note_request(r);
		sent++;
	endtask

	task automatic write_queue_size(input logic [8:0] v);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.apply_queue_size(v);
		@(posedge clk);
	endtask

	// A well-formed life cycle: allocate a few entries, link them into one chain
	// with the next flag on all but the last (mostly off there); usually free it.
	task automatic run_chain(input int max_len);
		int           n;
		logic [7:0]   got[$];
		dflm_result_t p;
		dflm_req_t    r;
		n = $urandom_range(1, max_len);
		repeat (n) begin
			send(make_request(KIND_ALLOC, 16'($urandom), {$urandom, $urandom}, $urandom,
				16'($urandom), 16'($urandom)), p);
			if (p.status == STAT_OK)
				got.push_back(p.granted);
		end
		foreach (got[i]) begin
			r = random_request(sb.entries_in_use);
			r.kind = KIND_SET;
			r.slot = {8'd0, got[i]};
			if (i + 1 < got.size()) begin
				r.desc_flags_in[0] = 1'b1;
				r.link_in = {8'd0, got[i + 1]};
			end else if ($urandom_range(0, 3) != 0) begin
				r.desc_flags_in[0] = 1'b0;
			end
			send(r, p);
		end
		if (got.size() != 0 && $urandom_range(0, 4) != 0)
			send(make_request(KIND_FREE, {8'd0, got[0]}, {$urandom, $urandom}, $urandom,
				16'($urandom), 16'($urandom)), p);
	endtask

	// Directed opening at the reset queue size of 256, then at a size of 4.
	task automatic run_directed();
		dflm_result_t p;
		// Widest values of every field, and set/free outside the table.
		send(make_request(KIND_SET, 16'd255, '1, '1, 16'hFFFF, 16'hFFFF), p);
		send(make_request(KIND_SET, 16'd0, '0, '0, 16'h0000, 16'h0000), p);
		send(make_request(KIND_SET, 16'hFFFF, {$urandom, $urandom}, $urandom,
			16'hFFFF, 16'h0001), p);
		send(make_request(KIND_FREE, 16'hFFFF, '0, '0, '0, '0), p);
		send(make_request(KIND_UNKNOWN, 16'd0, '1, '1, '1, '1), p);
		send(make_request(KIND_ALLOC, 16'd0, '0, '0, '0, '0), p);
		// Entry 255 has the next flag but an end-mark link: one entry back.
		send(make_request(KIND_FREE, 16'd255, '0, '0, '0, '0), p);
		// Freeing it again must not push the count past the queue size.
		send(make_request(KIND_FREE, 16'd255, '0, '0, '0, '0), p);
		send(make_request(KIND_ALLOC, 16'd0, '0, '0, '0, '0), p);
		// An entry that links to itself: the walk meets it again, freed and with its flag clear, and stops.
		send(make_request(KIND_SET, 16'd5, '0, 32'd64, 16'h0001, 16'd5), p);
		send(make_request(KIND_FREE, 16'd5, '0, '0, '0, '0), p);

		// Sizes the block must refuse, then a small table.
		write_queue_size(9'd0);
		write_queue_size(9'd3);
		write_queue_size(9'd511);
		write_queue_size(9'd4);

		// Drain the list and try once more on an empty one.
		repeat (5)
			send(make_request(KIND_ALLOC, 16'd0, '0, '0, '0, '0), p);
		send(make_request(KIND_SET, 16'd0, 64'h1000, 32'd16, 16'h0001, 16'd1), p);
		send(make_request(KIND_SET, 16'd1, 64'h2000, 32'd32, 16'h0000, 16'd3), p);
		send(make_request(KIND_FREE, 16'd0, '0, '0, '0, '0), p);
		// Corrupt the head entry's link so the list points outside the table:
		// the second allocate fails although the count is not zero.
		send(make_request(KIND_SET, 16'd1, '0, '0, 16'h0000, 16'd9), p);
		send(make_request(KIND_ALLOC, 16'd0, '0, '0, '0, '0), p);
		send(make_request(KIND_ALLOC, 16'd0, '0, '0, '0, '0), p);
		send(make_request(KIND_SET, 16'd4, '1, '1, '1, '1), p);
		send(make_request(KIND_FREE, 16'd4, '0, '0, '0, '0), p);
		send(make_request(KIND_FREE, 16'd3, '0, '0, '0, '0), p);
	endtask

	task automatic run_phase(input int p);
		int           phase_end;
		int           qs;
		dflm_result_t pr;
		write_queue_size(9'(refused_qs[p]));
		write_queue_size(9'(phase_qs[p]));
		idle_pct = idle_plan[p % 4];
		qs = phase_qs[p];
		phase_end = sent + PHASE_ITEMS;
		while (sent < phase_end) begin
			if ($urandom_range(0, 99) < 70) begin
				if (qs <= 4)
					run_chain(qs);
				else if ($urandom_range(0, 9) == 0)
					run_chain((qs < 16) ? qs : 16);
				else
					run_chain(4);
			end else begin
				send(random_request(qs), pr);
			end
		end
	endtask

	initial begin
		sb = new();
		sent = 0;
		idle_pct = 0;
		arst_n <= 1'b0;
		start <= 1'b0;
		req <= '0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		for (int p = 0; p < PHASES; p++)
			run_phase(p);

		// Final drain with a bound, so a missing result shows up as a
		// leftover prediction rather than only as a timeout.
		start <= 1'b0;
		for (int w = 0; w < 5000 && sb.pending() != 0; w++)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d predicted results never came", sb.pending()));

		if (sb.errors == 0)
			$display("descriptor_free_list_manager: match");
		else
			$display("descriptor_free_list_manager: mismatch");
		$finish;
	end

	// Even with every request walking a full 256-entry chain the run stays
	// well inside this bound.
	initial begin
		#10ms;
		$display("descriptor_free_list_manager: mismatch");
		$finish;
	end

endmodule

// ===== sim.f =====
src/dflm_pkg.sv
src/descriptor_free_list_manager.sv
tb/tb_top.sv
